/* sv/zbpp_pkg.sv */
package zbpp_pkg;

  localparam int ACC_W = 50;
  localparam int PIX_W = 13;
  localparam int CNT_W = 6;
  localparam logic [31:0] DEPTH_MAX = 32'h7fff_ffff;
  localparam logic [31:0] DEPTH_MIN = 32'h8000_0000;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PROJECT = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_OCCLUDED = 3'd1;
  localparam logic [2:0] ST_OUTSIDE = 3'd2;
  localparam logic [2:0] ST_ZERO_DEPTH = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic [2:0] REG_WIDTH = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROW0_AB = 3'd2;
  localparam logic [2:0] REG_ROW0_CD = 3'd3;
  localparam logic [2:0] REG_ROW1_AB = 3'd4;
  localparam logic [2:0] REG_ROW1_CD = 3'd5;
  localparam logic [2:0] REG_ROW2_AB = 3'd6;
  localparam logic [2:0] REG_ROW2_CD = 3'd7;

  typedef struct packed {
    logic we;
    logic [2:0] status;
  } zbpp_dummy_t;

endpackage

/* sv/zbpp_store.sv */
module zbpp_store #(
  parameter int DEPTH = 262144,
  parameter int WIDTH = 53
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/zbuffer_point_projection.sv */
// Z-buffer point projection. A start transfer is taken when start is high and
// busy is low; each clear, projection or read gives one result, shown on the
// result ports for one cycle with done high, and the receiver cannot stall it.
// A projection forms the nine products on the shared multiplier, then runs two
// 50-bit divisions on the shared one-bit-per-cycle divider, then does a
// read-modify-write of the pixel store. A clear sweeps all
// MAX_WIDTH*MAX_HEIGHT store entries one entry per cycle, and the same sweep
// runs after reset with busy high; configuration writes are taken at any time.
module zbuffer_point_projection #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int ID_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [19:0] point_id,
  input  logic [8:0]  read_col,
  input  logic [8:0]  read_row,
  output logic        done,
  output logic [2:0]  status,
  output logic [8:0]  pixel_col,
  output logic [8:0]  pixel_row,
  output logic [19:0] winner_id,
  output logic signed [31:0] winner_depth
);
  import zbpp_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int ENTW = 1 + ID_BITS + 32;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_ACC, S_ZCHK, S_DIV, S_DIVEND, S_ADDR, S_RD, S_RDW
  } state_t;

  state_t state;
  logic [9:0] image_width, image_height;
  logic [63:0] row0_ab, row0_cd, row1_ab, row1_cd, row2_ab, row2_cd;

  logic [1:0] op;
  logic signed [31:0] px, py, pz;
  logic [ID_BITS-1:0] pid;
  logic [1:0] ri, ti;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc, u, v, w;
  logic [ACC_W-1:0] dvd, dvs;
  logic [ACC_W:0] rem;
  logic [CNT_W-1:0] cnt;
  logic neg, phase, col_ok, report;
  logic [PIX_W-1:0] col_q, row_q;
  logic [AW-1:0] addr;

  logic we;
  logic [ENTW-1:0] wdata, rdata;

  logic cfg_wr;
  logic [PIX_W-1:0] act_w, act_h;
  logic signed [31:0] coef, opnd;
  logic signed [63:0] prod_sh;
  logic signed [ACC_W-1:0] base, sum;
  logic [ACC_W:0] rem_sh;
  logic qbit;
  logic q_in;
  logic [ID_BITS+19:0] id_ext;
  logic [ID_BITS+19:0] win_ext;
  logic stored_occ;
  logic [ID_BITS-1:0] stored_id;
  logic signed [31:0] stored_depth;
  logic [31:0] depth_sat;
  logic wins;

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[5:3])
      REG_WIDTH:   prdata = {54'd0, image_width};
      REG_HEIGHT:  prdata = {54'd0, image_height};
      REG_ROW0_AB: prdata = row0_ab;
      REG_ROW0_CD: prdata = row0_cd;
      REG_ROW1_AB: prdata = row1_ab;
      REG_ROW1_CD: prdata = row1_cd;
      REG_ROW2_AB: prdata = row2_ab;
      REG_ROW2_CD: prdata = row2_cd;
      default:     prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 10'd512;
      image_height <= 10'd512;
      row0_ab <= '0;
      row0_cd <= '0;
      row1_ab <= '0;
      row1_cd <= '0;
      row2_ab <= '0;
      row2_cd <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_WIDTH:   image_width <= pwdata[9:0];
        REG_HEIGHT:  image_height <= pwdata[9:0];
        REG_ROW0_AB: row0_ab <= pwdata;
        REG_ROW0_CD: row0_cd <= pwdata;
        REG_ROW1_AB: row1_ab <= pwdata;
        REG_ROW1_CD: row1_cd <= pwdata;
        REG_ROW2_AB: row2_ab <= pwdata;
        REG_ROW2_CD: row2_cd <= pwdata;
        default: ;
      endcase
    end
  end

  assign act_w = (PIX_W'(image_width) > PIX_W'(MAX_WIDTH)) ? PIX_W'(MAX_WIDTH)
                                                            : PIX_W'(image_width);
  assign act_h = (PIX_W'(image_height) > PIX_W'(MAX_HEIGHT)) ? PIX_W'(MAX_HEIGHT)
                                                              : PIX_W'(image_height);

  // coefficient and operand for the shared multiplier
  always_comb begin
    unique case (ri)
      2'd0: begin
        base = $signed(ACC_W'($signed(row0_cd[31:0])));
        coef = (ti == 2'd0) ? $signed(row0_ab[63:32])
             : (ti == 2'd1) ? $signed(row0_ab[31:0]) : $signed(row0_cd[63:32]);
      end
      2'd1: begin
        base = $signed(ACC_W'($signed(row1_cd[31:0])));
        coef = (ti == 2'd0) ? $signed(row1_ab[63:32])
             : (ti == 2'd1) ? $signed(row1_ab[31:0]) : $signed(row1_cd[63:32]);
      end
      default: begin
        base = $signed(ACC_W'($signed(row2_cd[31:0])));
        coef = (ti == 2'd0) ? $signed(row2_ab[63:32])
             : (ti == 2'd1) ? $signed(row2_ab[31:0]) : $signed(row2_cd[63:32]);
      end
    endcase
    opnd = (ti == 2'd0) ? px : (ti == 2'd1) ? py : pz;
  end

  assign prod_sh = prod >>> 16;
  assign sum = ((ti == 2'd0) ? base : acc) + $signed(prod_sh[ACC_W-1:0]);

  assign rem_sh = {rem[ACC_W-1:0], dvd[ACC_W-1]};
  assign qbit = (rem_sh >= {1'b0, dvs});

  assign q_in = (dvd < ACC_W'(phase ? act_h : act_w)) && ((dvd == '0) || !neg);

  assign id_ext = {{ID_BITS{1'b0}}, point_id};

  assign stored_occ = rdata[ENTW-1];
  assign stored_id = rdata[ID_BITS+31:32];
  assign stored_depth = $signed(rdata[31:0]);
  assign win_ext = {20'd0, stored_id};

  always_comb begin
    if (!w[ACC_W-1] && (w[ACC_W-2:31] != '0)) begin
      depth_sat = DEPTH_MAX;
    end else if (w[ACC_W-1] && (w[ACC_W-2:31] != '1)) begin
      depth_sat = DEPTH_MIN;
    end else begin
      depth_sat = w[31:0];
    end
  end

  assign wins = !stored_occ || ($signed(depth_sat) < stored_depth);

  always_comb begin
    we = 1'b0;
    wdata = {1'b0, {ID_BITS{1'b0}}, DEPTH_MAX};
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_RDW && op == OP_PROJECT && wins) begin
      we = 1'b1;
      wdata = {1'b1, pid, depth_sat};
    end
  end

  zbpp_store #(
    .DEPTH(DEPTH),
    .WIDTH(ENTW)
  ) u_store (
    .clk(clk),
    .we(we),
    .addr(addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      addr <= '0;
      report <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
            if (report) begin
              done <= 1'b1;
              status <= ST_OK;
              pixel_col <= '0;
              pixel_row <= '0;
              winner_id <= '0;
              winner_depth <= '0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            op <= operation;
            unique case (operation)
              OP_CLEAR: begin
                state <= S_CLEAR;
                addr <= '0;
                report <= 1'b1;
              end
              OP_PROJECT: begin
                px <= coord_x;
                py <= coord_y;
                pz <= coord_z;
                pid <= id_ext[ID_BITS-1:0];
                ri <= 2'd0;
                ti <= 2'd0;
                state <= S_MUL;
              end
              OP_READ: begin
                col_q <= PIX_W'(read_col);
                row_q <= PIX_W'(read_row);
                if (PIX_W'(read_col) >= act_w || PIX_W'(read_row) >= act_h) begin
                  done <= 1'b1;
                  status <= ST_OUTSIDE;
                  pixel_col <= read_col;
                  pixel_row <= read_row;
                  winner_id <= '0;
                  winner_depth <= '0;
                end else begin
                  state <= S_ADDR;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          prod <= coef * opnd;
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= sum;
          state <= S_MUL;
          if (ti == 2'd2) begin
            ti <= 2'd0;
            ri <= ri + 2'd1;
            unique case (ri)
              2'd0: u <= sum;
              2'd1: v <= sum;
              default: begin
                w <= sum;
                state <= S_ZCHK;
              end
            endcase
          end else begin
            ti <= ti + 2'd1;
          end
        end
        S_ZCHK: begin
          if (w == '0) begin
            done <= 1'b1;
            status <= ST_ZERO_DEPTH;
            pixel_col <= '0;
            pixel_row <= '0;
            winner_id <= '0;
            winner_depth <= '0;
            state <= S_IDLE;
          end else begin
            dvd <= u[ACC_W-1] ? ACC_W'(-u) : ACC_W'(u);
            dvs <= w[ACC_W-1] ? ACC_W'(-w) : ACC_W'(w);
            neg <= u[ACC_W-1] ^ w[ACC_W-1];
            rem <= '0;
            cnt <= CNT_W'(ACC_W - 1);
            phase <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= qbit ? (rem_sh - {1'b0, dvs}) : rem_sh;
          dvd <= {dvd[ACC_W-2:0], qbit};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_DIVEND;
          end
        end
        S_DIVEND: begin
          if (!phase) begin
            col_ok <= q_in;
            col_q <= dvd[PIX_W-1:0];
            dvd <= v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
            neg <= v[ACC_W-1] ^ w[ACC_W-1];
            rem <= '0;
            cnt <= CNT_W'(ACC_W - 1);
            phase <= 1'b1;
            state <= S_DIV;
          end else if (col_ok && q_in) begin
            row_q <= dvd[PIX_W-1:0];
            state <= S_ADDR;
          end else begin
            done <= 1'b1;
            status <= ST_OUTSIDE;
            pixel_col <= '0;
            pixel_row <= '0;
            winner_id <= '0;
            winner_depth <= '0;
            state <= S_IDLE;
          end
        end
        S_ADDR: begin
          addr <= AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);
          state <= S_RD;
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          done <= 1'b1;
          pixel_col <= col_q[8:0];
          pixel_row <= row_q[8:0];
          state <= S_IDLE;
          if (op == OP_READ) begin
            status <= stored_occ ? ST_OK : ST_EMPTY;
            winner_id <= win_ext[19:0];
            winner_depth <= stored_depth;
          end else if (wins) begin
            status <= ST_OK;
            winner_id <= 20'(pid);
            winner_depth <= $signed(depth_sat);
          end else begin
            status <= ST_OCCLUDED;
            winner_id <= win_ext[19:0];
            winner_depth <= stored_depth;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/zbpp_checker.sv */
module zbpp_checker
  import zbpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  input  logic [19:0] point_id,
  input  logic [8:0]  read_col,
  input  logic [8:0]  read_row,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [8:0]  pixel_col,
  input  logic [8:0]  pixel_row,
  input  logic [19:0] winner_id,
  input  logic [31:0] winner_depth,
  output int          pending,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_W = 512;
  localparam int FRAME_H = 512;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [19:0] id;
    logic [31:0] depth;
  } pixel_result_t;

  pixel_result_t result_q[$];
  logic [9:0]  img_w, img_h;
  logic [63:0] coef_ab[3];
  logic [63:0] coef_cd[3];
  logic [31:0] depth_mem[int];
  logic [19:0] id_mem[int];

  assign pending = result_q.size();

  function automatic longint mul_q16(logic [31:0] a, logic [31:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    return p >>> 16;
  endfunction

  function automatic longint row_sum(int r, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return mul_q16(coef_ab[r][63:32], x) + mul_q16(coef_ab[r][31:0], y)
         + mul_q16(coef_cd[r][63:32], z) + longint'($signed(coef_cd[r][31:0]));
  endfunction

  function automatic int act_w();
    return (img_w > FRAME_W) ? FRAME_W : int'(img_w);
  endfunction

  function automatic int act_h();
    return (img_h > FRAME_H) ? FRAME_H : int'(img_h);
  endfunction

  function automatic pixel_result_t project_point(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [19:0] id);
    longint u, v, w, col, row;
    int a;
    logic [31:0] d;
    pixel_result_t res;
    res = '0;
    u = row_sum(0, x, y, z);
    v = row_sum(1, x, y, z);
    w = row_sum(2, x, y, z);
    if (w == 0) begin
      res.status = ST_ZERO_DEPTH;
      return res;
    end
    col = u / w;
    row = v / w;
    if (col < 0 || col >= act_w() || row < 0 || row >= act_h()) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    if (w > 64'sh7fffffff) w = 64'sh7fffffff;
    else if (w < -64'sh80000000) w = -64'sh80000000;
    d = w[31:0];
    a = int'(row) * FRAME_W + int'(col);
    res.col = col[8:0];
    res.row = row[8:0];
    if (!depth_mem.exists(a) || $signed(d) < $signed(depth_mem[a])) begin
      depth_mem[a] = d;
      id_mem[a] = id;
      res.status = ST_OK;
      res.id = id;
      res.depth = d;
    end else begin
      res.status = ST_OCCLUDED;
      res.id = id_mem[a];
      res.depth = depth_mem[a];
    end
    return res;
  endfunction

  function automatic pixel_result_t read_pixel(logic [8:0] c, logic [8:0] r);
    pixel_result_t res;
    int a;
    res = '0;
    res.col = c;
    res.row = r;
    if (c >= act_w() || r >= act_h()) begin
      res.status = ST_OUTSIDE;
      return res;
    end
    a = int'(r) * FRAME_W + int'(c);
    if (depth_mem.exists(a)) begin
      res.status = ST_OK;
      res.id = id_mem[a];
      res.depth = depth_mem[a];
    end else begin
      res.status = ST_EMPTY;
      res.depth = DEPTH_MAX;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pixel_result_t got, want;
    if (rst) begin
      img_w = 10'd512;
      img_h = 10'd512;
      for (int i = 0; i < 3; i++) begin
        coef_ab[i] = '0;
        coef_cd[i] = '0;
      end
      depth_mem.delete();
      id_mem.delete();
      result_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_WIDTH: img_w = pwdata[9:0];
          REG_HEIGHT: img_h = pwdata[9:0];
          REG_ROW0_AB: coef_ab[0] = pwdata;
          REG_ROW0_CD: coef_cd[0] = pwdata;
          REG_ROW1_AB: coef_ab[1] = pwdata;
          REG_ROW1_CD: coef_cd[1] = pwdata;
          REG_ROW2_AB: coef_ab[2] = pwdata;
          REG_ROW2_CD: coef_cd[2] = pwdata;
          default: ;
        endcase
      end
      if (done) begin
        got = '{status, pixel_col, pixel_row, winner_id, winner_depth};
        if (result_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
          end
          if (got.col !== want.col) begin
            $error("pixel_col expected %0d actual %0d", want.col, got.col);
            errors++;
          end
          if (got.row !== want.row) begin
            $error("pixel_row expected %0d actual %0d", want.row, got.row);
            errors++;
          end
          if (got.id !== want.id) begin
            $error("winner_id expected %0h actual %0h", want.id, got.id);
            errors++;
          end
          if (got.depth !== want.depth) begin
            $error("winner_depth expected %0h actual %0h", want.depth, got.depth);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        case (operation)
          OP_CLEAR: begin
            depth_mem.delete();
            id_mem.delete();
            result_q.push_back('0);
          end
          OP_PROJECT: result_q.push_back(project_point(coord_x, coord_y, coord_z, point_id));
          OP_READ: result_q.push_back(read_pixel(read_col, read_row));
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/zbuffer_point_projection_tb.sv */
module zbuffer_point_projection_tb;
  import zbpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam longint CYCLE_LIMIT = 8000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation = OP_READ;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [19:0] point_id = '0;
  logic [8:0] read_col = '0, read_row = '0;
  logic done;
  logic [2:0] status;
  logic [8:0] pixel_col, pixel_row;
  logic [19:0] winner_id;
  logic signed [31:0] winner_depth;
  int pending, errors;
  longint cycles = 0;
  int cur_w = 512, cur_h = 512;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  zbuffer_point_projection dut (.*);

  zbpp_checker checker_i (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("zbuffer_point_projection_tb: errors");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0 || busy) @(negedge clk);
    repeat (150) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic setup(logic [9:0] w, logic [9:0] h, logic [63:0] r0ab, logic [63:0] r0cd,
                       logic [63:0] r1ab, logic [63:0] r1cd, logic [63:0] r2ab,
                       logic [63:0] r2cd);
    wait_idle();
    reg_write(REG_WIDTH, {54'd0, w});
    reg_write(REG_HEIGHT, {54'd0, h});
    reg_write(REG_ROW0_AB, r0ab);
    reg_write(REG_ROW0_CD, r0cd);
    reg_write(REG_ROW1_AB, r1ab);
    reg_write(REG_ROW1_CD, r1cd);
    reg_write(REG_ROW2_AB, r2ab);
    reg_write(REG_ROW2_CD, r2cd);
    cur_w = (w > 512) ? 512 : int'(w);
    cur_h = (h > 512) ? 512 : int'(h);
  endtask

  task automatic identity(logic [9:0] w, logic [9:0] h);
    setup(w, h, {ONE, 32'd0}, 64'd0, {32'd0, ONE}, 64'd0, 64'd0, {ONE, 32'd0});
  endtask

  task automatic issue(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                       logic [19:0] id, logic [8:0] c, logic [8:0] r);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
    repeat (gap + 1) @(negedge clk);
    operation <= op;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    point_id <= id;
    read_col <= c;
    read_row <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic hit(int c, int r, logic [31:0] z, logic [19:0] id);
    logic [31:0] x, y;
    x = c * z + $urandom_range(0, z - 1);
    y = r * z + $urandom_range(0, z - 1);
    issue(OP_PROJECT, x, y, z, id, $urandom, $urandom);
  endtask

  task automatic random_item();
    int k, c, r;
    logic [31:0] z;
    k = $urandom_range(0, 99);
    if (k < 72 && cur_w > 0 && cur_h > 0) begin
      if ($urandom_range(0, 1)) begin
        c = $urandom_range(0, (cur_w < 6 ? cur_w : 6) - 1);
        r = $urandom_range(0, (cur_h < 6 ? cur_h : 6) - 1);
        z = $urandom_range(1, 8) << 14;
      end else begin
        c = $urandom_range(0, cur_w - 1);
        r = $urandom_range(0, cur_h - 1);
        z = $urandom_range(1, 1 << 20);
      end
      hit(c, r, z, $urandom);
    end else if (k < 88) begin
      if ($urandom_range(0, 3) == 0 || cur_w == 0 || cur_h == 0)
        issue(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        issue(OP_READ, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(0, (cur_w < 6 ? cur_w : 6) - 1),
              $urandom_range(0, (cur_h < 6 ? cur_h : 6) - 1));
    end else if (k < 97) begin
      issue(OP_PROJECT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      issue(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default coefficients: every point has zero depth
    issue(OP_PROJECT, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 20'hfffff, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 9'd511, 9'd511);
    issue(OP_READ, 0, 0, 0, 0, 9'd0, 9'd0);

    identity(10'd512, 10'd512);
    hit(0, 0, ONE, 20'h00001);
    hit(0, 0, ONE, 20'h00002);
    hit(0, 0, ONE >> 1, 20'hfffff);
    hit(511, 511, 32'h7fff, 20'h12345);
    issue(OP_PROJECT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 20'h0, 0, 0);
    issue(OP_PROJECT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'h1, 0, 0);
    issue(OP_PROJECT, 32'hffff_0000, 32'h0, 32'hffff_0000, 20'h2, 0, 0);
    issue(OP_PROJECT, 32'h0, 32'h0, 32'h0, 20'h3, 0, 0);
    issue(OP_PROJECT, 32'h0, 32'h0, 32'hffff_0000, 20'h4, 0, 0);
    issue(OP_PROJECT, 32'h0200_0000, 32'h0, ONE, 20'h5, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 9'd0, 9'd0);
    issue(OP_READ, 0, 0, 0, 0, 9'd511, 9'd511);
    issue(OP_READ, 0, 0, 0, 0, 9'd3, 9'd7);
    issue(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 20'hfffff, 9'h1ff, 9'h1ff);
    issue(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 9'd0, 9'd0);

    setup(10'd0, 10'd512, {ONE, 32'd0}, 64'd0, {32'd0, ONE}, 64'd0, 64'd0, {ONE, 32'd0});
    hit(0, 0, ONE, 20'h7);
    issue(OP_READ, 0, 0, 0, 0, 9'd0, 9'd0);

    identity(10'd512, 10'd512);
    for (int i = 0; i < 700; i++) begin
      if (i == 350) issue(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, 0, 0);
      random_item();
    end

    identity(10'd1, 10'd1);
    for (int i = 0; i < 150; i++) random_item();

    setup(10'd1023, 10'd1023, {ONE << 1, 32'd0}, {32'd0, 32'h0003_0000},
          {32'd0, ONE}, {32'hffff_8000, 32'd0}, 64'd0, {ONE, 32'h0000_8000});
    for (int i = 0; i < 300; i++) random_item();

    setup(10'h3ff, 10'h3ff, {$urandom, $urandom}, {$urandom, $urandom},
          {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
          {$urandom, $urandom});
    for (int i = 0; i < 200; i++) random_item();

    identity(10'd37, 10'd300);
    for (int i = 0; i < 300; i++) random_item();

    while (pending != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("zbuffer_point_projection_tb: clean");
    end else begin
      $display("zbuffer_point_projection_tb: errors");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/zbpp_pkg.sv
sv/zbpp_store.sv
sv/zbuffer_point_projection.sv
tb/zbpp_checker.sv
tb/zbuffer_point_projection_tb.sv
